// File: rtl/core/smavg_pkg.sv
`default_nettype none
package smavg_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int AVG_W          = 24;
  localparam int FRAC_W         = 8;
  localparam int MODE_W         = 2;
  localparam int WLEN_W         = 7;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 7;
  localparam int DEF_MAX_WINDOW = 64;

  localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_FILL_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 2'd1;

  localparam logic [MODE_W-1:0] MODE_PRELOAD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ZERO    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PASS    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SCALED  = 2'd3;

endpackage
`default_nettype wire

// File: rtl/core/smavg_if.sv
`default_nettype none
interface smavg_sample_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [smavg_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface smavg_average_if;
  logic                               valid;
  logic                               ready;
  logic signed [smavg_pkg::AVG_W-1:0] average;

  modport source (output valid, output average, input ready);
  modport sink (input valid, input average, output ready);
endinterface

interface smavg_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [smavg_pkg::CFG_IDX_W-1:0]    index;
  logic [smavg_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/smavg_div.sv
`default_nettype none
module smavg_div #(
  parameter int DVD_W = 22,
  parameter int DVS_W = smavg_pkg::WLEN_W
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic signed [DVD_W-1:0]          dividend,
  input  wire logic        [DVS_W-1:0]          divisor,
  output logic                                  done,
  output logic signed [smavg_pkg::AVG_W-1:0]    quotient
);
  import smavg_pkg::*;

  localparam int NUM_W = DVD_W + FRAC_W;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] num_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic             neg_r;

  logic [DVD_W-1:0] mag;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;
  logic [NUM_W-1:0] q_signed;

  assign mag      = dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
  assign trial    = {rem_r, num_r[NUM_W-1]};
  assign diff     = trial - {1'b0, dvs_r};
  assign ge       = (trial >= {1'b0, dvs_r});
  assign q_signed = neg_r ? NUM_W'(-num_r) : num_r;
  assign quotient = AVG_W'(q_signed);
  assign done     = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[DVD_W-1];
      num_r <= {mag, {FRAC_W{1'b0}}};
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      num_r <= {num_r[NUM_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/simple_moving_average_unit.sv
// Simple moving average over the last window_len signed 16-bit samples.
// Channels: in_req carries one sample per request, out_rsp returns one
// signed Q16.8 average per sample (mean times 256, truncated toward zero),
// cfg_wr writes fill_mode (index 0) or window_len (index 1); cfg_wr is
// always ready and any write to a known index restarts the window fill.
// Throughput: one sample at a time. A sliding-window or sample-over-count
// sample goes through the bit-serial divider, which resolves one quotient
// bit per cycle. A preload sample writes itself into every slot of the
// window, one ring write per cycle; zero and pass-through fill samples
// skip the divider. in_req.ready is high only while the unit is idle.
// The result sits in an output register; when the receiver stalls, the
// unit holds the next finished result and stays busy until it drains.
// Reset: fill_mode 0, window_len 8, empty window, no result pending.
// The sample ring needs no clearing; every slot is written before read.
`default_nettype none
module simple_moving_average_unit #(
  parameter int MAX_WINDOW = smavg_pkg::DEF_MAX_WINDOW
) (
  input wire logic          clk,
  input wire logic          rst_n,
  smavg_sample_if.sink      in_req,
  smavg_average_if.source   out_rsp,
  smavg_cfg_if.sink         cfg_wr
);
  import smavg_pkg::*;

  localparam int AW    = $clog2(MAX_WINDOW);
  localparam int SUM_W = SAMPLE_W + $clog2(MAX_WINDOW);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_DISPATCH = 3'd1;
  localparam logic [2:0] ST_PRELOAD  = 3'd2;
  localparam logic [2:0] ST_SLIDE    = 3'd3;
  localparam logic [2:0] ST_DIVSTART = 3'd4;
  localparam logic [2:0] ST_DIV      = 3'd5;
  localparam logic [2:0] ST_FINISH   = 3'd6;

  logic [2:0]                  state_r, state_nxt;
  logic [MODE_W-1:0]           mode_r;
  logic [WLEN_W-1:0]           wlen_r;
  logic signed [SUM_W-1:0]     sum_r, sum_nxt;
  logic [AW-1:0]               wp_r, wp_nxt;
  logic [WLEN_W-1:0]           fill_r, fill_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        div_fill_r, div_fill_nxt;
  logic signed [SAMPLE_W-1:0]  samp_r;
  logic [WLEN_W-1:0]           len_r;
  logic signed [AVG_W-1:0]     res_r, res_nxt;
  logic signed [AVG_W-1:0]     out_avg_r;

  logic signed [SAMPLE_W-1:0]  ring [MAX_WINDOW];
  logic signed [SAMPLE_W-1:0]  rdata_r;
  logic                        ring_we;
  logic                        ring_re;

  logic [WLEN_W-1:0]           eff_len;
  logic                        wp_wrap;
  logic [AW-1:0]               wp_adv;
  logic                        in_acc;
  logic                        cfg_hit;
  logic                        div_start;
  logic                        div_done;
  logic signed [SUM_W-1:0]     div_dvd;
  logic [WLEN_W-1:0]           div_dvs;
  logic signed [AVG_W-1:0]     div_q;
  logic signed [AVG_W-1:0]     samp_q8;

  assign in_acc          = in_req.valid && in_req.ready;
  assign in_req.ready    = (state_r == ST_IDLE);
  assign cfg_wr.ready    = 1'b1;
  assign cfg_hit         = cfg_wr.valid &&
                           (cfg_wr.index == CFG_FILL_MODE || cfg_wr.index == CFG_WINDOW_LEN);
  assign out_rsp.valid   = out_valid_r;
  assign out_rsp.average = out_avg_r;

  assign wp_wrap = (32'(wp_r) + 32'd1 == 32'(len_r));
  assign wp_adv  = wp_wrap ? '0 : wp_r + 1'b1;
  assign samp_q8 = {samp_r, {FRAC_W{1'b0}}};
  assign div_dvd = div_fill_r ? SUM_W'(samp_r) : sum_r;
  assign div_dvs = div_fill_r ? fill_r : len_r;

  always_comb begin
    if (wlen_r == '0) begin
      eff_len = WLEN_W'(1);
    end else if (32'(wlen_r) > MAX_WINDOW) begin
      eff_len = WLEN_W'(MAX_WINDOW);
    end else begin
      eff_len = wlen_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    sum_nxt       = sum_r;
    wp_nxt        = wp_r;
    fill_nxt      = fill_r;
    res_nxt       = res_r;
    div_fill_nxt  = div_fill_r;
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    ring_we       = 1'b0;
    ring_re       = 1'b0;
    div_start     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (fill_r < len_r) begin
          if (mode_r == MODE_PRELOAD) begin
            state_nxt = ST_PRELOAD;
          end else begin
            ring_we  = 1'b1;
            sum_nxt  = sum_r + SUM_W'(samp_r);
            fill_nxt = fill_r + 1'b1;
            wp_nxt   = wp_adv;
            case (mode_r)
              MODE_ZERO: begin
                res_nxt   = '0;
                state_nxt = ST_FINISH;
              end
              MODE_PASS: begin
                res_nxt   = samp_q8;
                state_nxt = ST_FINISH;
              end
              default: begin
                div_fill_nxt = 1'b1;
                state_nxt    = ST_DIVSTART;
              end
            endcase
          end
        end else begin
          ring_re   = 1'b1;
          state_nxt = ST_SLIDE;
        end
      end
      ST_PRELOAD: begin
        ring_we = 1'b1;
        sum_nxt = sum_r + SUM_W'(samp_r);
        wp_nxt  = wp_adv;
        if (wp_wrap) begin
          fill_nxt  = len_r;
          res_nxt   = samp_q8;
          state_nxt = ST_FINISH;
        end
      end
      ST_SLIDE: begin
        ring_we      = 1'b1;
        sum_nxt      = sum_r - SUM_W'(rdata_r) + SUM_W'(samp_r);
        wp_nxt       = wp_adv;
        div_fill_nxt = 1'b0;
        state_nxt    = ST_DIVSTART;
      end
      ST_DIVSTART: begin
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          res_nxt   = div_q;
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_PRELOAD;
      wlen_r      <= WLEN_RESET;
      sum_r       <= '0;
      wp_r        <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      div_fill_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      div_fill_r  <= div_fill_nxt;
      if (cfg_hit) begin
        if (cfg_wr.index == CFG_FILL_MODE) begin
          mode_r <= cfg_wr.data[MODE_W-1:0];
        end else begin
          wlen_r <= cfg_wr.data[WLEN_W-1:0];
        end
        sum_r  <= '0;
        wp_r   <= '0;
        fill_r <= '0;
      end else begin
        sum_r  <= sum_nxt;
        wp_r   <= wp_nxt;
        fill_r <= fill_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (in_acc) begin
      samp_r <= in_req.sample;
      len_r  <= eff_len;
    end
    if (state_r == ST_FINISH && (!out_valid_r || out_rsp.ready)) begin
      out_avg_r <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[wp_r] <= samp_r;
    end
    if (ring_re) begin
      rdata_r <= ring[wp_r];
    end
  end

  smavg_div #(
    .DVD_W (SUM_W),
    .DVS_W (WLEN_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

endmodule
`default_nettype wire
